@@ rtl/cpc_pkg.sv @@
package cpc_pkg;

    // Field and datapath widths
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned DT_W      = 16;
    localparam int unsigned LIM_W     = 31;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned ERR_W     = 33;
    localparam int unsigned DIFF_W    = 23;
    localparam int unsigned DMAG_W    = DIFF_W - 1;
    localparam int unsigned INTEG_W   = 35;
    localparam int unsigned SUM_W     = 50;

    // Serial multiplier: accumulator half and step counter
    localparam int unsigned MUL_HI_W  = DATA_W + 2;
    localparam int unsigned MUL_CNT_W = 6;
    localparam logic [MUL_CNT_W-1:0] MUL_DT_STEPS   = MUL_CNT_W'(DT_W);
    localparam logic [MUL_CNT_W-1:0] MUL_GAIN_STEPS = MUL_CNT_W'(DATA_W);

    // Serial divider: numerator is |error change| scaled by 2^16
    localparam int unsigned DIV_NUM_W = DMAG_W + DT_W;
    localparam int unsigned DIV_CNT_W = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd4;

    // Constants of the control law
    localparam logic signed [ERR_W-1:0]  ERR_BOUND = 33'sd1310720;
    localparam logic signed [DATA_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN     = 32'sh8000_0000;
    localparam logic [LIM_W-1:0]         LIM_RESET = 31'h7FFF_FFFF;

    typedef struct packed {
        logic                        start;
        logic                        b_signed;
        logic [MUL_CNT_W-1:0]        steps;
        logic signed [DATA_W-1:0]    a;
        logic [DATA_W-1:0]           b;
    } t_mul_req;

    typedef struct packed {
        logic                        start;
        logic [DIV_NUM_W-1:0]        num;
        logic [DT_W-1:0]             den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

@@ rtl/clamped_pid_controller_core.sv @@
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_target, i_measured, i_step_time
// result    out        o_out_valid / i_out_stall    o_drive
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A sample that takes the bypass (all gains zero or |error| above 20.0) goes
// from S_CHECK straight to S_OUT. A regular sample runs a 16-step serial
// multiply for error*dt, then three 32-step serial multiplies for the gain
// terms; the 38-step serial divide for the derivative runs alongside the
// first multiply. One sample is in work at a time.
// Reset is synchronous, active low; gains clear, limits go to full scale.
// A finished result waits in the output register under i_out_stall while the
// next sample is already taken; the config port is always ready.
module clamped_pid_controller_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [cpc_pkg::DATA_W-1:0]     i_target,
    input  logic signed [cpc_pkg::DATA_W-1:0]     i_measured,
    input  logic [cpc_pkg::DT_W-1:0]              i_step_time,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [cpc_pkg::DATA_W-1:0]     o_drive,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [cpc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [cpc_pkg::DATA_W-1:0]            i_cfg_data
);
    import cpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INTEG,
        S_CLAMP,
        S_DERIV,
        S_PROD,
        S_PWAIT,
        S_SAT,
        S_OUT
    } t_state;

    localparam logic [1:0] TERM_LAST = 2'd2;

    // Configuration and loop state
    logic signed [DATA_W-1:0]  r_gain_p;
    logic signed [DATA_W-1:0]  r_gain_i;
    logic signed [DATA_W-1:0]  r_gain_d;
    logic [LIM_W-1:0]          r_drive_lim;
    logic [LIM_W-1:0]          r_integ_lim;
    logic signed [DATA_W-1:0]  r_integ_acc;
    logic signed [DATA_W-1:0]  r_last_err;

    // Per-sample working registers
    t_state                    r_state;
    logic signed [DATA_W-1:0]  r_meas;
    logic [DT_W-1:0]           r_dt;
    logic signed [ERR_W-1:0]   r_err;
    logic                      r_diff_neg;
    logic signed [INTEG_W-1:0] r_integ_raw;
    logic signed [DATA_W-1:0]  r_deriv;
    logic signed [SUM_W-1:0]   r_sum;
    logic [1:0]                r_term;
    logic signed [DATA_W-1:0]  r_result;
    logic                      r_div_fin;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_drive;
    t_mul_req                  r_mul_req;
    t_div_req                  r_div_req;

    // Arithmetic unit results
    t_unit_stat                mul_stat;
    t_unit_stat                div_stat;
    logic signed [MUL_HI_W-1:0] mul_hi;
    logic [DATA_W-1:0]         mul_lo;
    logic [DIV_NUM_W-1:0]      div_quot;

    logic signed [ERR_W-1:0]   n_err;
    logic                      n_bypass;
    logic signed [DIFF_W-1:0]  n_diff;
    logic [DMAG_W-1:0]         n_diff_mag;
    logic signed [INTEG_W-1:0] n_ilim;
    logic signed [DATA_W-1:0]  n_integ_clamped;
    logic                      n_q_big;
    logic signed [DATA_W-1:0]  n_deriv_sat;
    logic signed [SUM_W-1:0]   n_mul_floor;
    logic signed [SUM_W-1:0]   n_dlim;
    logic signed [DATA_W-1:0]  n_drive_clamped;
    logic signed [DATA_W-1:0]  n_op_a;
    logic [DATA_W-1:0]         n_op_b;

    cpc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mul_req),
        .o_stat  (mul_stat),
        .o_hi    (mul_hi),
        .o_lo    (mul_lo)
    );

    cpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // Error, bypass test and error change
    always_comb begin
        n_err      = ERR_W'(i_target) - ERR_W'(i_measured);
        n_bypass   = (r_gain_p == '0 && r_gain_i == '0 && r_gain_d == '0) ||
                     (r_err > ERR_BOUND) || (r_err < -ERR_BOUND);
        n_diff     = DIFF_W'(r_err) - DIFF_W'(r_last_err);
        n_diff_mag = n_diff[DIFF_W-1] ? DMAG_W'(-n_diff) : DMAG_W'(n_diff);
    end

    // Clamp the new integral to the symmetric limit
    always_comb begin
        n_ilim = INTEG_W'($signed({1'b0, r_integ_lim}));
        if (r_integ_raw > n_ilim) begin
            n_integ_clamped = DATA_W'(n_ilim);
        end else if (r_integ_raw < -n_ilim) begin
            n_integ_clamped = DATA_W'(-n_ilim);
        end else begin
            n_integ_clamped = DATA_W'(r_integ_raw);
        end
    end

    // Apply sign to the quotient magnitude and saturate to 32 bits; a zero step time gives zero
    always_comb begin
        n_q_big = |div_quot[DIV_NUM_W-1:DATA_W-1];
        if (r_dt == '0) begin
            n_deriv_sat = '0;
        end else if (!r_diff_neg) begin
            n_deriv_sat = n_q_big ? Q_MAX : $signed({1'b0, div_quot[DATA_W-2:0]});
        end else begin
            n_deriv_sat = n_q_big ? Q_MIN : -$signed({1'b0, div_quot[DATA_W-2:0]});
        end
    end

    // Pick the gain and the term for the current product
    always_comb begin
        case (r_term)
            2'd0: begin
                n_op_a = r_gain_p;
                n_op_b = DATA_W'(r_err);
            end
            2'd1: begin
                n_op_a = r_gain_i;
                n_op_b = r_integ_acc;
            end
            default: begin
                n_op_a = r_gain_d;
                n_op_b = r_deriv;
            end
        endcase
    end

    // Floor of a gain product by 2^16, then the output clamp
    always_comb begin
        n_mul_floor = $signed({{(SUM_W-48){mul_hi[DATA_W-1]}}, mul_hi[DATA_W-1:0],
                               mul_lo[DATA_W-1:DT_W]});
        n_dlim      = SUM_W'($signed({1'b0, r_drive_lim}));
        if (r_sum > n_dlim) begin
            n_drive_clamped = DATA_W'(n_dlim);
        end else if (r_sum < -n_dlim) begin
            n_drive_clamped = DATA_W'(-n_dlim);
        end else begin
            n_drive_clamped = DATA_W'(r_sum);
        end
    end

    // Sequencer, configuration registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_gain_p        <= '0;
            r_gain_i        <= '0;
            r_gain_d        <= '0;
            r_drive_lim     <= LIM_RESET;
            r_integ_lim     <= LIM_RESET;
            r_integ_acc     <= '0;
            r_last_err      <= '0;
            r_out_valid     <= 1'b0;
            r_div_fin       <= 1'b0;
            r_term          <= '0;
            r_mul_req.start <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            r_mul_req.start <= 1'b0;
            r_div_req.start <= 1'b0;
            if (div_stat.done) begin
                r_div_fin <= 1'b1;
            end

            // Register writes; unknown indexes drop
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_GAIN_PROP:   r_gain_p    <= i_cfg_data;
                    CFG_GAIN_INTEG:  r_gain_i    <= i_cfg_data;
                    CFG_GAIN_DERIV:  r_gain_d    <= i_cfg_data;
                    CFG_DRIVE_LIMIT: r_drive_lim <= i_cfg_data[LIM_W-1:0];
                    CFG_INTEG_LIMIT: r_integ_lim <= i_cfg_data[LIM_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Release the output register once its transaction completes
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_meas  <= i_measured;
                        r_dt    <= i_step_time;
                        r_err   <= n_err;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (n_bypass) begin
                        r_result <= '0;
                        r_state  <= S_OUT;
                    end else begin
                        r_mul_req  <= '{start: 1'b1, b_signed: 1'b0, steps: MUL_DT_STEPS,
                                       a: DATA_W'(r_err), b: DATA_W'(r_dt)};
                        r_div_req  <= '{start: 1'b1, num: {n_diff_mag, {DT_W{1'b0}}},
                                       den: r_dt};
                        r_diff_neg <= n_diff[DIFF_W-1];
                        r_div_fin  <= 1'b0;
                        r_last_err <= DATA_W'(r_err);
                        r_sum      <= SUM_W'(r_meas);
                        r_state    <= S_INTEG;
                    end
                end
                S_INTEG: begin
                    if (mul_stat.done) begin
                        r_integ_raw <= INTEG_W'(r_integ_acc) + INTEG_W'(mul_hi);
                        r_state     <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_integ_acc <= n_integ_clamped;
                    r_state     <= S_DERIV;
                end
                S_DERIV: begin
                    if (r_div_fin) begin
                        r_deriv <= n_deriv_sat;
                        r_term  <= '0;
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    r_mul_req <= '{start: 1'b1, b_signed: 1'b1, steps: MUL_GAIN_STEPS,
                                  a: n_op_a, b: n_op_b};
                    r_state   <= S_PWAIT;
                end
                S_PWAIT: begin
                    if (mul_stat.done) begin
                        r_sum <= r_sum + n_mul_floor;
                        if (r_term == TERM_LAST) begin
                            r_state <= S_SAT;
                        end else begin
                            r_term  <= r_term + 2'd1;
                            r_state <= S_PROD;
                        end
                    end
                end
                S_SAT: begin
                    r_result <= n_drive_clamped;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_drive     <= r_result;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_cfg_ready = 1'b1;

    // The multiplier is never restarted mid-product
    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_req.start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    // The divider is never restarted mid-quotient
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_req.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // An accepted sample closes the input until it is done
    a_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // A new result only comes from the output state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output state");

endmodule

@@ rtl/cpc_mul.sv @@
module cpc_mul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  cpc_pkg::t_mul_req                      i_req,
    output cpc_pkg::t_unit_stat                    o_stat,
    output logic signed [cpc_pkg::MUL_HI_W-1:0]    o_hi,
    output logic [cpc_pkg::DATA_W-1:0]             o_lo
);
    import cpc_pkg::*;

    logic signed [MUL_HI_W-1:0] r_hi;
    logic [DATA_W-1:0]          r_lo;
    logic [DATA_W-1:0]          r_b;
    logic signed [DATA_W-1:0]   r_a;
    logic [MUL_CNT_W-1:0]       r_cnt;
    logic                       r_bsigned;
    logic                       r_done;

    logic signed [MUL_HI_W-1:0] n_pp;
    logic signed [MUL_HI_W-1:0] n_sum;

    // Add the partial product of one multiplier bit; subtract it for a signed top bit
    always_comb begin
        n_pp  = r_b[0] ? MUL_HI_W'(r_a) : '0;
        n_sum = (r_cnt == MUL_CNT_W'(1) && r_bsigned) ? (r_hi - n_pp) : (r_hi + n_pp);
    end

    // Load operands on start, then shift one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a       <= i_req.a;
                r_b       <= i_req.b;
                r_bsigned <= i_req.b_signed;
                r_cnt     <= i_req.steps;
                r_hi      <= '0;
                r_lo      <= '0;
            end else if (r_cnt != '0) begin
                r_hi   <= n_sum >>> 1;
                r_lo   <= {n_sum[0], r_lo[DATA_W-1:1]};
                r_b    <= r_b >> 1;
                r_cnt  <= r_cnt - MUL_CNT_W'(1);
                r_done <= (r_cnt == MUL_CNT_W'(1));
            end
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_hi        = r_hi;
    assign o_lo        = r_lo;

endmodule

@@ rtl/cpc_div.sv @@
module cpc_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cpc_pkg::t_div_req                  i_req,
    output cpc_pkg::t_unit_stat                o_stat,
    output logic [cpc_pkg::DIV_NUM_W-1:0]      o_quot
);
    import cpc_pkg::*;

    logic [DT_W-1:0]      r_rem;
    logic [DT_W-1:0]      r_den;
    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [DT_W+1:0]      n_trial;
    logic                 n_qbit;
    logic [DT_W-1:0]      n_rem;

    // Restoring step: shift in the next numerator bit and try the subtract
    always_comb begin
        n_trial = {1'b0, r_rem, r_q[DIV_NUM_W-1]} - {2'b00, r_den};
        n_qbit  = ~n_trial[DT_W+1];
        n_rem   = n_qbit ? n_trial[DT_W-1:0] : {r_rem[DT_W-2:0], r_q[DIV_NUM_W-1]};
    end

    // Numerator bits leave at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q   <= i_req.num;
                r_den <= i_req.den;
                r_rem <= '0;
                r_cnt <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_cnt != '0) begin
                r_rem  <= n_rem;
                r_q    <= {r_q[DIV_NUM_W-2:0], n_qbit};
                r_cnt  <= r_cnt - DIV_CNT_W'(1);
                r_done <= (r_cnt == DIV_CNT_W'(1));
            end
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

endmodule

@@ verif/tb_clamped_pid_controller_core.sv @@
`timescale 1ns / 1ps

module tb_clamped_pid_controller_core;
    import cpc_pkg::*;

    localparam longint ONE     = 65536;
    localparam longint ERR_LIM = longint'(ERR_BOUND);
    localparam int     PHASES  = 14;
    localparam int     PHASE_N = 105;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] measured;
    logic [DT_W-1:0]          step_time;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] drive;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;

    // Controller settings and state as the predictor sees them
    longint prop_gain, integ_gain, deriv_gain;
    longint drive_cap, integ_cap;
    longint integ_sum, prev_error;

    logic signed [DATA_W-1:0] pending_drive[$];
    logic signed [DATA_W-1:0] want_drive;
    int                       fail_count = 0;
    bit                       idle_en = 1'b1;
    int                       hold_len = 0;

    clamped_pid_controller_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_target    (target),
        .i_measured  (measured),
        .i_step_time (step_time),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_drive     (drive),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < 40) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        fail_count++;
    endtask

    function automatic longint limit_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Advance the controller state by one sample and return the expected drive
    function automatic logic signed [DATA_W-1:0] predict_drive(
        input logic signed [DATA_W-1:0] tgt,
        input logic signed [DATA_W-1:0] meas,
        input logic [DT_W-1:0]          dt
    );
        longint err, dtl, deriv, total;
        dtl = dt;
        if (prop_gain == 0 && integ_gain == 0 && deriv_gain == 0) return '0;
        err = longint'(tgt) - longint'(meas);
        if (err > ERR_LIM || err < -ERR_LIM) return '0;

        integ_sum = limit_sym(integ_sum + ((err * dtl) >>> 16), integ_cap);

        if (dtl != 0) begin
            deriv = ((err - prev_error) * ONE) / dtl;
        end else begin
            deriv = 0;
        end
        if (deriv > longint'(Q_MAX)) deriv = longint'(Q_MAX);
        if (deriv < longint'(Q_MIN)) deriv = longint'(Q_MIN);

        total = longint'(meas)
              + ((prop_gain * err) >>> 16)
              + ((integ_gain * integ_sum) >>> 16)
              + ((deriv_gain * deriv) >>> 16);
        total = limit_sym(total, drive_cap);
        prev_error = err;
        return total[DATA_W-1:0];
    endfunction

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (pending_drive.size() == 0) begin
                report_mismatch($sformatf("drive %0d with nothing expected", drive));
            end else begin
                want_drive = pending_drive.pop_front();
                if (drive !== want_drive) begin
                    report_mismatch($sformatf("drive %0d, expected %0d", drive, want_drive));
                end
            end
        end
    end

    // Result side: random stall per transaction, or one long hold when asked
    initial begin
        int unsigned wait_n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_len != 0) begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end else begin
                wait_n = idle_en ? $urandom_range(0, 5) : 0;
                if (wait_n != 0) begin
                    out_stall <= 1'b1;
                    repeat (wait_n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // Write one register; keep valid high when another write follows
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_GAIN_PROP:   prop_gain  = $signed(data);
            CFG_GAIN_INTEG:  integ_gain = $signed(data);
            CFG_GAIN_DERIV:  deriv_gain = $signed(data);
            CFG_DRIVE_LIMIT: drive_cap  = data[LIM_W-1:0];
            CFG_INTEG_LIMIT: integ_cap  = data[LIM_W-1:0];
            default: ;
        endcase
        if (last) cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
                                input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] dlim,
                                input logic [DATA_W-1:0] ilim);
        // Throw in a write to an unmapped index now and then
        if ($urandom_range(0, 1) == 1) begin
            write_reg(CFG_IDX_W'($urandom_range(CFG_INTEG_LIMIT + 1, (1 << CFG_IDX_W) - 1)),
                      $urandom(), 1'b0);
        end
        write_reg(CFG_GAIN_PROP, kp, 1'b0);
        write_reg(CFG_GAIN_INTEG, ki, 1'b0);
        write_reg(CFG_GAIN_DERIV, kd, 1'b0);
        write_reg(CFG_DRIVE_LIMIT, dlim, 1'b0);
        write_reg(CFG_INTEG_LIMIT, ilim, 1'b1);
    endtask

    // Offer one sample and record its expected drive once accepted
    task automatic send_sample(input logic signed [DATA_W-1:0] tgt,
                               input logic signed [DATA_W-1:0] meas,
                               input logic [DT_W-1:0] dt);
        int unsigned gap;
        gap = idle_en ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        target    <= tgt;
        measured  <= meas;
        step_time <= dt;
        do @(posedge clk); while (in_stall !== 1'b0);
        pending_drive.push_back(predict_drive(tgt, meas, dt));
    endtask

    // Pick a random measurement and place the target at the given error
    task automatic send_error_sample(input longint err, input logic [DT_W-1:0] dt);
        longint meas, tgt;
        meas = longint'($signed($urandom()));
        tgt  = meas + err;
        if (tgt > longint'(Q_MAX) || tgt < longint'(Q_MIN)) begin
            tgt  = meas;
            meas = meas - err;
        end
        send_sample(tgt[DATA_W-1:0], meas[DATA_W-1:0], dt);
    endtask

    // Drop valid and hold until every expected drive has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge clk);
    endtask

    function automatic longint rand_error();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return longint'($urandom_range(0, 4 * ONE)) - 2 * ONE;
            4: begin
                case ($urandom_range(0, 3))
                    0: return ERR_LIM;
                    1: return -ERR_LIM;
                    2: return ERR_LIM + 1;
                    default: return -ERR_LIM - 1;
                endcase
            end
            default: return longint'($urandom_range(0, 2 * ERR_LIM)) - ERR_LIM;
        endcase
    endfunction

    function automatic logic [DT_W-1:0] rand_step();
        case ($urandom_range(0, 5))
            0, 1:    return DT_W'($urandom_range(1, 64));
            2:       return $urandom_range(0, 1) ? {DT_W{1'b1}} : DT_W'(1);
            default: return DT_W'($urandom_range(1, (1 << DT_W) - 1));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return Q_MAX;
            2:       return Q_MIN;
            3:       return $urandom();
            default: return DATA_W'(longint'($urandom_range(0, 8 * ONE)) - 4 * ONE);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return LIM_RESET;
            2:       return $urandom();
            default: return $urandom_range(0, 200 * ONE);
        endcase
    endfunction

    task automatic random_sample();
        // Mostly in-band errors; now and then raw noise on both fields
        if ($urandom_range(0, 9) == 0) begin
            send_sample($urandom(), $urandom(), rand_step());
        end else begin
            send_error_sample(rand_error(), rand_step());
        end
    endtask

    // Gains at reset are zero: every sample bypasses to zero drive
    task automatic test_gains_zero();
        write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), $urandom(), 1'b1);
        send_sample(Q_MAX, Q_MIN, {DT_W{1'b1}});
        send_sample(Q_MIN, Q_MAX, DT_W'(1));
        send_sample('0, '0, DT_W'(1));
        send_error_sample(ERR_LIM, DT_W'(1000));
        drain_results();
    endtask

    // Error exactly at and just past the bound, measurements at full scale
    task automatic test_error_bound();
        program_regs(DATA_W'(ONE), DATA_W'(ONE / 2), DATA_W'(ONE / 4), LIM_RESET, LIM_RESET);
        send_sample(DATA_W'(ERR_LIM), '0, DT_W'(1));
        send_sample(DATA_W'(-ERR_LIM), '0, {DT_W{1'b1}});
        send_sample(DATA_W'(ERR_LIM + 1), '0, DT_W'(7));
        send_sample('0, DATA_W'(ERR_LIM + 1), DT_W'(300));
        send_sample(Q_MAX, Q_MAX, {DT_W{1'b1}});
        send_sample(Q_MIN, Q_MIN, DT_W'(1));
        send_sample(Q_MAX, DATA_W'(longint'(Q_MAX) - ONE), DT_W'(1));
        send_sample(Q_MIN, DATA_W'(longint'(Q_MIN) + ONE), DT_W'(1));
        drain_results();
    endtask

    // Full-scale gains against zero limits, then against full limits
    task automatic test_extreme_settings();
        program_regs(Q_MIN, Q_MAX, Q_MIN, '0, '0);
        repeat (3) send_error_sample(rand_error(), rand_step());
        drain_results();
        program_regs(Q_MAX, Q_MIN, Q_MAX, LIM_RESET, LIM_RESET);
        repeat (3) send_error_sample(rand_error(), rand_step());
        drain_results();
    endtask

    // Push the integral into its clamp on both sides
    task automatic test_integ_clamp();
        program_regs(DATA_W'(ONE / 8), DATA_W'(2 * ONE), '0, DATA_W'(3 * ONE), DATA_W'(ONE / 2));
        repeat (4) send_error_sample(ERR_LIM, {DT_W{1'b1}});
        repeat (4) send_error_sample(-ERR_LIM, {DT_W{1'b1}});
        drain_results();
    endtask

    // Random settings per phase; some phases run without any idling
    task automatic test_random_phases();
        for (int ph = 0; ph < PHASES; ph++) begin
            idle_en = (ph % 5 != 4);
            program_regs(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit());
            repeat (PHASE_N) random_sample();
            drain_results();
        end
        idle_en = 1'b1;
    endtask

    // Hold the result side off long enough for the input to back up
    task automatic test_output_backpressure();
        program_regs(DATA_W'(ONE), DATA_W'(ONE / 4), DATA_W'(ONE / 16), LIM_RESET,
                     DATA_W'(100 * ONE));
        hold_len = 800;
        repeat (24) send_error_sample(rand_error(), rand_step());
        drain_results();
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        target    = '0;
        measured  = '0;
        step_time = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        prop_gain  = 0;
        integ_gain = 0;
        deriv_gain = 0;
        drive_cap  = LIM_RESET;
        integ_cap  = LIM_RESET;
        integ_sum  = 0;
        prev_error = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_gains_zero();
        test_error_bound();
        test_extreme_settings();
        test_integ_clamp();
        test_random_phases();
        test_output_backpressure();

        // Let any stray result show up before the verdict
        drain_results();
        repeat (300) @(posedge clk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cpc_pkg.sv
rtl/cpc_mul.sv
rtl/cpc_div.sv
rtl/clamped_pid_controller_core.sv
verif/tb_clamped_pid_controller_core.sv
